>>> design/agfc_pkg.sv
`default_nettype none
package agfc_pkg;
    localparam int FREQ_W = 22;
    localparam int ACT_W = 11;
    localparam int WIN_W = 4;
    localparam int RATIO_W = 7;
    localparam int CORE_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 22;
    localparam int DEF_CLUSTER_CORES = 4;
    localparam int DEF_HISTORY_DEPTH = 10;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_CLAMP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATIO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CLAMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATIO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd7;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        OUT_PASS = 2'd0,
        OUT_RELEASED = 2'd1,
        OUT_CLAMPED = 2'd2
    } outcome_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_ACC, ST_DIV, ST_PCT, ST_NEXT, ST_DONE, ST_OUT
    } state_t;
endpackage
`default_nettype wire

>>> design/agfc_if.sv
`default_nettype none
interface agfc_in_if;
    logic valid;
    logic ready;
    logic command;
    logic [1:0] core_index;
    logic [10:0] activity;
    logic [21:0] requested_freq;
    logic boost_active;
    modport source (output valid, command, core_index, activity, requested_freq,
                    boost_active, input ready);
    modport sink (input valid, command, core_index, activity, requested_freq,
                  boost_active, output ready);
endinterface

interface agfc_out_if;
    logic valid;
    logic ready;
    logic [21:0] granted_freq;
    logic [1:0] outcome;
    modport source (output valid, granted_freq, outcome, input ready);
    modport sink (input valid, granted_freq, outcome, output ready);
endinterface
`default_nettype wire

>>> design/agfc_ram.sv
`default_nettype none
module agfc_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 40
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> design/agfc_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module agfc_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [DEN_W+1:0] trial;

    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg, q_reg[NUM_W-1]};
        if (start)
        begin
            q_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {2'b00, den_reg})
            begin
                rem_next = (DEN_W+1)'(trial - {2'b00, den_reg});
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W:0];
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign quot = q_next;
endmodule
`default_nettype wire

>>> design/activity_gated_frequency_clamp_core.sv
`default_nettype none
// Clamps a cluster's requested frequency against activity history held in one
// synchronous RAM of CLUSTER_CORES*HISTORY_DEPTH entries. After reset the RAM is
// cleared, one entry a cycle, before the first request is taken. A sample
// request writes its activity into that core's history. A frequency request
// that needs the history walks each core's window, one RAM read (ST_READ) and
// one add (ST_ACC) per entry, with the window cut to HISTORY_DEPTH, and then
// divides the sum serially; no new request is taken until the result of the
// last one has been taken. One result is given per frequency request and none
// per sample.
module activity_gated_frequency_clamp_core
    import agfc_pkg::*;
#(
    parameter int CLUSTER_CORES = DEF_CLUSTER_CORES,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    agfc_in_if.sink                    in_req,
    agfc_out_if.source                 out_res
);
    localparam int ENTRIES = CLUSTER_CORES * HISTORY_DEPTH;
    localparam int ADDR_W = $clog2(ENTRIES);
    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CID_W = (CLUSTER_CORES > 1) ? $clog2(CLUSTER_CORES) : 1;
    localparam int SUM_W = ACT_W + 4;
    localparam int PCT_W = 18;

    logic [FREQ_W-1:0] min_clamp_reg, max_clamp_reg, floor_reg, ceiling_reg;
    logic [WIN_W-1:0] min_window_reg, max_window_reg;
    logic [RATIO_W-1:0] min_ratio_reg, max_ratio_reg;

    logic [PTR_W-1:0] widx_reg [CLUSTER_CORES];
    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg;
    logic [CID_W-1:0] core_reg;
    logic [PTR_W-1:0] pos_reg;
    logic [WIN_W-1:0] k_reg, n_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [$clog2(CLUSTER_CORES+1)-1:0] count_reg;
    logic is_max_reg;
    logic [FREQ_W-1:0] req_reg, clamp_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic out_valid_reg;
    logic [FREQ_W-1:0] out_freq_reg;
    outcome_t out_code_reg;

    logic ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ACT_W-1:0] ram_wdata, ram_rdata;
    logic div_start, div_done;
    logic [SUM_W-1:0] div_q;
    logic [PTR_W-1:0] pos_prev;

    agfc_ram #(.WIDTH(ACT_W), .DEPTH(ENTRIES)) u_hist (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    agfc_div #(.NUM_W(SUM_W), .DEN_W(WIN_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(sum_reg), .den(n_reg),
        .done(div_done), .quot(div_q)
    );

    function automatic logic [FREQ_W-1:0] limit(input logic [FREQ_W-1:0] f,
                                                 input logic [FREQ_W-1:0] lo,
                                                 input logic [FREQ_W-1:0] hi);
        logic [FREQ_W-1:0] r;
        r = (f < lo) ? lo : f;
        r = (r > hi) ? hi : r;
        return r;
    endfunction

    assign pos_prev = (pos_reg == '0) ? PTR_W'(HISTORY_DEPTH - 1) : pos_reg - 1'b1;
    assign ram_raddr = ADDR_W'(core_reg * HISTORY_DEPTH + pos_prev);
    assign in_req.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_res.valid = out_valid_reg;
    assign out_res.granted_freq = out_freq_reg;
    assign out_res.outcome = out_code_reg;

    logic accept;
    logic core_ok;
    logic is_max_in;
    logic need_walk;
    logic [WIN_W-1:0] win_in;
    logic [FREQ_W-1:0] clamp_in;
    logic [PCT_W-1:0] pct_full;
    logic [PCT_W-11:0] pct;
    logic hit;
    logic last_core;

    assign accept = in_req.valid && in_req.ready;
    assign core_ok = 32'(in_req.core_index) < CLUSTER_CORES;
    assign is_max_in = in_req.requested_freq > max_clamp_reg;
    assign clamp_in = is_max_in ? max_clamp_reg : min_clamp_reg;
    assign win_in = is_max_in ? max_window_reg : min_window_reg;
    assign need_walk = in_req.boost_active
        && (is_max_in || in_req.requested_freq < min_clamp_reg)
        && clamp_in != '0 && win_in != '0;
    assign pct_full = PCT_W'(div_q[ACT_W-1:0]) * PCT_W'(100);
    assign pct = pct_full[PCT_W-1:10];
    assign hit = is_max_reg ? (pct > (PCT_W-10)'(ratio_reg))
                            : (pct < (PCT_W-10)'(ratio_reg));
    assign last_core = 32'(core_reg) == CLUSTER_CORES - 1;

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        div_start = (state_reg == ST_DIV) && (k_reg == '0);
        if (state_reg == ST_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (accept && in_req.command == CMD_SAMPLE && core_ok)
        begin
            ram_we = 1'b1;
            ram_waddr = ADDR_W'(in_req.core_index * HISTORY_DEPTH
                                + widx_reg[CID_W'(in_req.core_index)]);
            ram_wdata = in_req.activity;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (32'(clr_reg) == ENTRIES - 1) state_next = ST_IDLE;
            ST_IDLE: if (accept && in_req.command == CMD_REQUEST && need_walk)
                state_next = ST_READ;
            ST_READ: state_next = ST_ACC;
            ST_ACC: state_next = (k_reg == WIN_W'(1)) ? ST_DIV : ST_READ;
            ST_DIV: if (div_done) state_next = ST_PCT;
            ST_PCT: state_next = last_core ? ST_DONE : ST_NEXT;
            ST_NEXT: state_next = ST_READ;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            min_clamp_reg <= '0;
            max_clamp_reg <= '0;
            floor_reg <= '0;
            ceiling_reg <= '1;
            min_window_reg <= '0;
            max_window_reg <= '0;
            min_ratio_reg <= '0;
            max_ratio_reg <= '0;
            for (int i = 0; i < CLUSTER_CORES; i++)
            begin
                widx_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MIN_CLAMP: min_clamp_reg <= cfg_data[FREQ_W-1:0];
                    REG_MIN_WINDOW: min_window_reg <= cfg_data[WIN_W-1:0];
                    REG_MIN_RATIO: min_ratio_reg <= cfg_data[RATIO_W-1:0];
                    REG_MAX_CLAMP: max_clamp_reg <= cfg_data[FREQ_W-1:0];
                    REG_MAX_WINDOW: max_window_reg <= cfg_data[WIN_W-1:0];
                    REG_MAX_RATIO: max_ratio_reg <= cfg_data[RATIO_W-1:0];
                    REG_FLOOR: floor_reg <= cfg_data[FREQ_W-1:0];
                    REG_CEILING: ceiling_reg <= cfg_data[FREQ_W-1:0];
                    default: ;
                endcase
            end
            if (accept && in_req.command == CMD_SAMPLE && core_ok)
            begin
                widx_reg[CID_W'(in_req.core_index)] <=
                    (32'(widx_reg[CID_W'(in_req.core_index)]) == HISTORY_DEPTH - 1)
                    ? '0 : widx_reg[CID_W'(in_req.core_index)] + 1'b1;
            end
            if (out_valid_reg && out_res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept && in_req.command == CMD_REQUEST && !need_walk)
            begin
                out_valid_reg <= 1'b1;
            end
            if (state_reg == ST_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_req.command == CMD_REQUEST)
        begin
            req_reg <= in_req.requested_freq;
            clamp_reg <= clamp_in;
            is_max_reg <= is_max_in;
            ratio_reg <= is_max_in ? max_ratio_reg : min_ratio_reg;
            n_reg <= (32'(win_in) > HISTORY_DEPTH) ? WIN_W'(HISTORY_DEPTH) : win_in;
            k_reg <= (32'(win_in) > HISTORY_DEPTH) ? WIN_W'(HISTORY_DEPTH) : win_in;
            core_reg <= '0;
            pos_reg <= widx_reg[0];
            sum_reg <= '0;
            count_reg <= '0;
            out_freq_reg <= in_req.requested_freq;
            out_code_reg <= OUT_PASS;
        end
        unique case (state_reg)
            ST_ACC:
            begin
                sum_reg <= sum_reg + SUM_W'(ram_rdata);
                pos_reg <= pos_prev;
                k_reg <= k_reg - 1'b1;
            end
            ST_DIV:
            begin
                k_reg <= n_reg;
            end
            ST_PCT:
            begin
                if (hit)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            ST_NEXT:
            begin
                core_reg <= core_reg + 1'b1;
                pos_reg <= widx_reg[core_reg + 1'b1];
                k_reg <= n_reg;
                sum_reg <= '0;
            end
            ST_DONE:
            begin
                if (is_max_reg ? (count_reg != '0) : (32'(count_reg) == CLUSTER_CORES))
                begin
                    out_freq_reg <= limit(req_reg, floor_reg, ceiling_reg);
                    out_code_reg <= OUT_RELEASED;
                end
                else
                begin
                    out_freq_reg <= limit(clamp_reg, floor_reg, ceiling_reg);
                    out_code_reg <= OUT_CLAMPED;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import agfc_pkg::*;

    localparam int CORES = DEF_CLUSTER_CORES;
    localparam int DEPTH = DEF_HISTORY_DEPTH;
    localparam int FREQ_MAX = 4194303;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic        command;
        logic [1:0]  core_index;
        logic [10:0] activity;
        logic [21:0] requested_freq;
        logic        boost_active;
        logic        known;
        logic [21:0] granted_freq;
        outcome_t    outcome;
    } stim_row_t;

    typedef struct {
        logic [21:0] granted_freq;
        outcome_t    outcome;
    } grant_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    agfc_in_if in_req ();
    agfc_out_if out_res ();

    activity_gated_frequency_clamp_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_req(in_req.sink),
        .out_res(out_res.source)
    );

    logic [21:0] min_clamp, max_clamp, floor_f, ceiling_f;
    logic [3:0]  min_win, max_win;
    logic [6:0]  min_pct, max_pct;
    logic [10:0] history [CORES][DEPTH];
    int          write_slot [CORES];

    grant_t grants_due[$];
    int     errors = 0;
    int     idle_cycles = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     recv_hold = 0;
    bit     all_sent = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic int core_percent(int core, int window);
        int n;
        int pos;
        int sum;
        n = (window > DEPTH) ? DEPTH : window;
        pos = write_slot[core];
        sum = 0;
        for (int k = 0; k < n; k++)
        begin
            pos = (pos == 0) ? DEPTH - 1 : pos - 1;
            sum += history[core][pos];
        end
        return ((sum / n) * 100) / 1024;
    endfunction

    function automatic logic [21:0] limit_freq(logic [21:0] f);
        logic [21:0] r;
        r = f;
        if (r < floor_f)
            r = floor_f;
        if (r > ceiling_f)
            r = ceiling_f;
        return r;
    endfunction

    function automatic grant_t decide_grant(logic [21:0] req, logic boost);
        grant_t g;
        bit is_max;
        logic [21:0] clamp;
        int window;
        int ratio;
        int hits;
        int p;
        bit released;
        g.granted_freq = req;
        g.outcome = OUT_PASS;
        hits = 0;
        if (boost && (req > max_clamp || req < min_clamp))
        begin
            is_max = req > max_clamp;
            clamp = is_max ? max_clamp : min_clamp;
            window = is_max ? max_win : min_win;
            ratio = is_max ? max_pct : min_pct;
            if (clamp != 0 && window != 0)
            begin
                for (int c = 0; c < CORES; c++)
                begin
                    p = core_percent(c, window);
                    if (is_max ? (p > ratio) : (p < ratio))
                        hits++;
                end
                released = is_max ? (hits > 0) : (hits == CORES);
                g.granted_freq = limit_freq(released ? req : clamp);
                g.outcome = released ? OUT_RELEASED : OUT_CLAMPED;
            end
        end
        return g;
    endfunction

    function automatic void record_sample(int core, logic [10:0] act);
        history[core][write_slot[core]] = act;
        write_slot[core] = (write_slot[core] + 1) % DEPTH;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MIN_CLAMP: min_clamp = 22'(value);
            REG_MIN_WINDOW: min_win = 4'(value);
            REG_MIN_RATIO: min_pct = 7'(value);
            REG_MAX_CLAMP: max_clamp = 22'(value);
            REG_MAX_WINDOW: max_win = 4'(value);
            REG_MAX_RATIO: max_pct = 7'(value);
            REG_FLOOR: floor_f = 22'(value);
            default: ceiling_f = 22'(value);
        endcase
    endtask

    task automatic drain_results();
        in_req.valid <= 1'b0;
        while (grants_due.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic send_request(stim_row_t r);
        grant_t g;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_req.valid <= 1'b0;
            @(negedge clk);
        end
        in_req.valid <= 1'b1;
        in_req.command <= r.command;
        in_req.core_index <= r.core_index;
        in_req.activity <= r.activity;
        in_req.requested_freq <= r.requested_freq;
        in_req.boost_active <= r.boost_active;
        @(posedge clk);
        while (!in_req.ready)
            @(posedge clk);
        if (r.command == CMD_SAMPLE)
            record_sample(r.core_index, r.activity);
        else
        begin
            g = decide_grant(r.requested_freq, r.boost_active);
            if (r.known && (g.granted_freq != r.granted_freq || g.outcome != r.outcome))
            begin
                $error("table row: granted_freq expected %0d got %0d, outcome %0d got %0d",
                       r.granted_freq, g.granted_freq, r.outcome, g.outcome);
                errors++;
            end
            if (r.known)
            begin
                g.granted_freq = r.granted_freq;
                g.outcome = r.outcome;
            end
            grants_due.push_back(g);
        end
        @(negedge clk);
    endtask

    function automatic stim_row_t make_row(logic cmd, int core, int act, int req,
                                           logic boost);
        stim_row_t r;
        r.command = cmd;
        r.core_index = 2'(core);
        r.activity = 11'(act);
        r.requested_freq = 22'(req);
        r.boost_active = boost;
        r.known = 1'b0;
        r.granted_freq = '0;
        r.outcome = OUT_PASS;
        return r;
    endfunction

    function automatic stim_row_t known_row(int req, logic boost, int grant, outcome_t oc);
        stim_row_t r;
        r = make_row(CMD_REQUEST, 0, 0, req, boost);
        r.known = 1'b1;
        r.granted_freq = 22'(grant);
        r.outcome = oc;
        return r;
    endfunction

    task automatic random_config();
        write_reg(REG_MIN_CLAMP, $urandom_range(3) == 0 ? 0 : $urandom_range(2000000));
        write_reg(REG_MIN_WINDOW, $urandom_range(15));
        write_reg(REG_MIN_RATIO, $urandom_range(3) == 0 ? 127 : $urandom_range(100));
        write_reg(REG_MAX_CLAMP, $urandom_range(3) == 0 ? 0 : $urandom_range(4194303, 2000000));
        write_reg(REG_MAX_WINDOW, $urandom_range(15));
        write_reg(REG_MAX_RATIO, $urandom_range(100));
        write_reg(REG_FLOOR, $urandom_range(4) == 0 ? FREQ_MAX : $urandom_range(1500000));
        write_reg(REG_CEILING, $urandom_range(4) == 0 ? 0 : $urandom_range(4194303, 1000000));
    endtask

    task automatic random_phase(int count);
        stim_row_t r;
        int act;
        for (int i = 0; i < count; i++)
        begin
            act = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(1024);
            if ($urandom_range(2) == 0)
                act = $urandom_range(1) ? 1024 : 0;
            if ($urandom_range(99) < 70)
                r = make_row(CMD_SAMPLE, $urandom_range(3), act, $urandom, 1'($urandom));
            else
                r = make_row(CMD_REQUEST, $urandom, $urandom,
                             $urandom_range(3) == 0 ? $urandom_range(FREQ_MAX, FREQ_MAX - 3)
                                                    : $urandom_range(FREQ_MAX),
                             $urandom_range(3) != 0);
            send_request(r);
        end
    endtask

    initial
    begin
        stim_row_t rows[$];
        for (int c = 0; c < CORES; c++)
        begin
            write_slot[c] = 0;
            for (int d = 0; d < DEPTH; d++)
                history[c][d] = '0;
        end
        min_clamp = 0; min_win = 0; min_pct = 0;
        max_clamp = 0; max_win = 0; max_pct = 0;
        floor_f = 0; ceiling_f = FREQ_MAX;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_req.valid = 1'b0;
        in_req.command = CMD_SAMPLE;
        in_req.core_index = '0;
        in_req.activity = '0;
        in_req.requested_freq = '0;
        in_req.boost_active = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        rows.push_back(known_row(0, 1'b1, 0, OUT_PASS));
        rows.push_back(known_row(FREQ_MAX, 1'b1, FREQ_MAX, OUT_PASS));
        rows.push_back(known_row(FREQ_MAX, 1'b0, FREQ_MAX, OUT_PASS));
        foreach (rows[i])
            send_request(rows[i]);
        drain_results();
        write_reg(REG_MIN_CLAMP, 1000);
        write_reg(REG_MIN_WINDOW, 15);
        write_reg(REG_MIN_RATIO, 50);
        write_reg(REG_MAX_CLAMP, 2000);
        write_reg(REG_MAX_WINDOW, 10);
        write_reg(REG_MAX_RATIO, 100);
        write_reg(REG_FLOOR, 500);
        write_reg(REG_CEILING, FREQ_MAX);
        rows.delete();
        rows.push_back(known_row(FREQ_MAX, 1'b1, 2000, OUT_CLAMPED));
        rows.push_back(known_row(0, 1'b1, 500, OUT_RELEASED));
        rows.push_back(known_row(1500, 1'b1, 1500, OUT_PASS));
        rows.push_back(make_row(CMD_SAMPLE, 0, 2047, 0, 1'b0));
        rows.push_back(make_row(CMD_SAMPLE, 1, 1024, FREQ_MAX, 1'b1));
        rows.push_back(make_row(CMD_SAMPLE, 2, 0, 0, 1'b0));
        rows.push_back(make_row(CMD_SAMPLE, 3, 1024, 0, 1'b0));
        rows.push_back(make_row(CMD_REQUEST, 0, 0, FREQ_MAX, 1'b1));
        rows.push_back(make_row(CMD_REQUEST, 3, 2047, 999, 1'b1));
        for (int k = 0; k < 12; k++)
            rows.push_back(make_row(CMD_SAMPLE, 2, 1024, 0, 1'b0));
        rows.push_back(make_row(CMD_REQUEST, 0, 0, 2001, 1'b1));
        foreach (rows[i])
            send_request(rows[i]);
        drain_results();
        write_reg(REG_FLOOR, 3000);
        write_reg(REG_CEILING, 100);
        send_request(known_row(FREQ_MAX, 1'b1, 100, OUT_CLAMPED));
        drain_results();

        for (int phase = 0; phase < 9; phase++)
        begin
            random_config();
            if (phase < 3)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 50;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 4)
            begin
                recv_hold = 1'b1;
                fork
                    begin
                        repeat (3000) @(negedge clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            random_phase(110);
            drain_results();
        end
        all_sent = 1'b1;
    end

    always @(negedge clk)
    begin
        out_res.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    initial
        out_res.ready = 1'b0;

    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n && out_res.valid && out_res.ready)
        begin
            if (grants_due.size() == 0)
            begin
                $error("granted_freq %0d arrived with nothing expected", out_res.granted_freq);
                errors++;
            end
            else
            begin
                g = grants_due.pop_front();
                if (out_res.granted_freq !== g.granted_freq)
                begin
                    $error("granted_freq expected %0d actual %0d",
                           g.granted_freq, out_res.granted_freq);
                    errors++;
                end
                if (out_res.outcome !== g.outcome)
                begin
                    $error("outcome expected %0d actual %0d", g.outcome, out_res.outcome);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (all_sent)
            begin
                if (errors == 0)
                    $display("PASS");
                else
                    $display("FAIL");
                $finish;
            end
            else if (idle_cycles > STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end
endmodule

>>> files.f
design/agfc_pkg.sv
design/agfc_if.sv
design/agfc_ram.sv
design/agfc_div.sv
design/activity_gated_frequency_clamp_core.sv
tb/sv/tb_top.sv
